/* rtl/core/cts_pkg.sv */
// Shared types and constants for the column to span converter.
package cts_pkg;

   localparam int ROWS  = 64;
   localparam int ROW_W = $clog2(ROWS);
   localparam int CNT_W = ROW_W + 1;
   localparam int COL_W = 10;
   localparam int TOP_W = 7;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [TOP_W-1:0] top_row;
      logic [ROW_W-1:0] bottom_row;
      logic             plane_start;
   } cts_req_type;

   typedef struct packed {
      logic [ROW_W-1:0] span_row;
      logic [COL_W-1:0] span_x_start;
      logic [COL_W-1:0] span_x_end;
      logic             last_of_run;
   } cts_rsp_type;

   typedef struct packed {
      logic load;
      logic close_top;
      logic close_bot;
      logic emit;
      logic open_top;
      logic open_bot;
   } cts_cmd_type;

   typedef struct packed {
      logic close_top_pending;
      logic close_bot_pending;
      logic open_top_pending;
      logic open_bot_pending;
      logic slot_free;
   } cts_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_EMIT,
      ST_OPEN
   } cts_state_type;

endpackage

/* rtl/core/cts_datapath.sv */
// Datapath: row range counters, start column memory and output word register.
module cts_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  cts_pkg::cts_req_type   req_word,
   input  cts_pkg::cts_cmd_type   cmd,
   output cts_pkg::cts_status_type status,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output cts_pkg::cts_rsp_type   rsp_word
);
   import cts_pkg::*;

   logic [COL_W-1:0] mem [ROWS];
   logic [COL_W-1:0] rdata_ff;

   logic [CNT_W-1:0] t1_ff, t1_in, b1_ff, b1_in, t2_ff, t2_in, b2_ff, b2_in;
   logic [TOP_W-1:0] prev_top_ff, prev_top_in;
   logic [ROW_W-1:0] prev_bottom_ff, prev_bottom_in;
   logic [COL_W-1:0] x_ff, x_in;
   logic [ROW_W-1:0] pend_row_ff, pend_row_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cts_rsp_type      rsp_word_ff, rsp_word_in;

   logic [TOP_W-1:0] top_sat;
   logic [ROW_W-1:0] rd_addr, wr_addr;
   logic             rd_en, wr_en;

   assign top_sat = (req_word.top_row > TOP_W'(ROWS)) ? TOP_W'(ROWS) : req_word.top_row;
   assign rd_addr = cmd.close_top ? t1_ff[ROW_W-1:0] : b1_ff[ROW_W-1:0];
   assign wr_addr = cmd.open_top  ? t2_ff[ROW_W-1:0] : b2_ff[ROW_W-1:0];
   assign rd_en   = cmd.close_top | cmd.close_bot;
   assign wr_en   = cmd.open_top  | cmd.open_bot;

   assign status.close_top_pending = (t1_ff < t2_ff) && (t1_ff <= b1_ff);
   assign status.close_bot_pending = (b1_ff > b2_ff) && (b1_ff >= t1_ff);
   assign status.open_top_pending  = (t2_ff < t1_ff) && (t2_ff <= b2_ff);
   assign status.open_bot_pending  = (b2_ff > b1_ff) && (b2_ff >= t2_ff);
   assign status.slot_free         = !rsp_valid_ff || rsp_ready;

   always_comb begin
      t1_in          = t1_ff;
      b1_in          = b1_ff;
      t2_in          = t2_ff;
      b2_in          = b2_ff;
      x_in           = x_ff;
      prev_top_in    = prev_top_ff;
      prev_bottom_in = prev_bottom_ff;
      pend_row_in    = pend_row_ff;
      if (cmd.load) begin
         // plane start sees the previous column as empty
         t1_in          = req_word.plane_start ? CNT_W'(ROWS) : CNT_W'(prev_top_ff);
         b1_in          = req_word.plane_start ? '0 : CNT_W'(prev_bottom_ff);
         t2_in          = CNT_W'(top_sat);
         b2_in          = CNT_W'(req_word.bottom_row);
         x_in           = req_word.column;
         prev_top_in    = top_sat;
         prev_bottom_in = req_word.bottom_row;
      end
      if (cmd.close_top) begin
         t1_in       = t1_ff + 1'b1;
         pend_row_in = rd_addr;
      end
      if (cmd.close_bot) begin
         b1_in       = b1_ff - 1'b1;
         pend_row_in = rd_addr;
      end
      if (cmd.open_top) begin
         t2_in = t2_ff + 1'b1;
      end
      if (cmd.open_bot) begin
         b2_in = b2_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (cmd.emit) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.span_row     = pend_row_ff;
         rsp_word_in.span_x_start = rdata_ff;
         rsp_word_in.span_x_end   = x_ff - 1'b1;
         // counters already stepped: anything left to close means more words
         rsp_word_in.last_of_run  = !(status.close_top_pending || status.close_bot_pending);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= x_ff;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      t1_ff       <= t1_in;
      b1_ff       <= b1_in;
      t2_ff       <= t2_in;
      b2_ff       <= b2_in;
      x_ff        <= x_in;
      pend_row_ff <= pend_row_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_top_ff    <= TOP_W'(ROWS);
         prev_bottom_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         prev_top_ff    <= prev_top_in;
         prev_bottom_ff <= prev_bottom_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* rtl/core/cts_ctrl.sv */
// Controller: sequences close, emit and open steps for one column.
module cts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cts_pkg::cts_status_type status,
   output cts_pkg::cts_cmd_type    cmd
);
   import cts_pkg::*;

   cts_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            // top closes first, ascending; then bottom, descending
            if (status.close_top_pending) begin
               cmd.close_top = 1'b1;
               state_in      = ST_EMIT;
            end else if (status.close_bot_pending) begin
               cmd.close_bot = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               state_in = ST_OPEN;
            end
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_CLOSE;
            end
         end
         ST_OPEN: begin
            if (status.open_top_pending) begin
               cmd.open_top = 1'b1;
            end else if (status.open_bot_pending) begin
               cmd.open_bot = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/column_to_span_converter.sv */
// Column to span converter: covered row ranges per column in, finished row spans out.
// One column word is taken at a time. Each row that closes needs a read of the start column
// memory and a step to load the output register; each row that opens needs one memory
// write. The output register lets the next column word be accepted while the last span
// word still waits; a stalled rsp_ready holds the close sequence.
// last_of_run marks the final span of a column. Send an empty column (top_row = 64) after
// the last real one to flush every open row.
module column_to_span_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cts_pkg::cts_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cts_pkg::cts_rsp_type rsp_word
);
   import cts_pkg::*;

   cts_cmd_type    cmd;
   cts_status_type status;

   cts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cts_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // a taken column word keeps the input closed for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready straight after a word was taken");

   // emitting into a full output register would drop a span
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.slot_free)
      else $error("span emitted while output register busy");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.close_top, cmd.close_bot, cmd.emit, cmd.open_top, cmd.open_bot}))
      else $error("more than one datapath command at once");

   // a close step is always followed by its emit
   assert property (@(posedge clock) disable iff (reset)
      (cmd.close_top || cmd.close_bot) |=> !(cmd.close_top || cmd.close_bot || cmd.load))
      else $error("close step not followed by emit");

endmodule
